// ===== rtl/aca_pkg.sv =====
// Shared types, constants and register codes for the ADC channel averager.
package aca_pkg;

   localparam int CHANNELS       = 4;
   localparam int SAMPLE_BITS    = 12;
   localparam int MAX_DEPTH_LOG2 = 7;

   localparam int CHAN_BITS      = 2;
   localparam int DEPTH_BITS     = 3;
   localparam int SUM_BITS       = SAMPLE_BITS + MAX_DEPTH_LOG2;
   localparam int WIDE_BITS      = SUM_BITS + 1;
   localparam int COUNT_BITS     = MAX_DEPTH_LOG2 + 1;
   localparam int TRIM_DEPTH     = 4;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = DEPTH_BITS;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};
   localparam logic [DEPTH_BITS-1:0]  DEPTH_LOG2_RESET = DEPTH_BITS'(2);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_MODE       = 1'b0,
      REG_DEPTH_LOG2 = 1'b1
   } csr_index_type;

   typedef enum logic {
      MODE_MEAN    = 1'b0,
      MODE_TRIMMED = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic [DEPTH_BITS-1:0]  depth_log2;
   } cfg_type;

   typedef struct packed {
      logic [SUM_BITS-1:0]    sum;
      logic [SAMPLE_BITS-1:0] min_val;
      logic [SAMPLE_BITS-1:0] max_val;
      logic [COUNT_BITS-1:0]  count;
   } chan_entry_type;

   localparam chan_entry_type CLEAR_ENTRY = '{
      sum:     '0,
      min_val: SAMPLE_MAX,
      max_val: '0,
      count:   '0
   };

endpackage

// ===== rtl/aca_stream_ifs.sv =====
// Valid/ready stream interfaces for the sample and result channels.
interface aca_req_if;
   logic                            valid;
   logic                            ready;
   logic [aca_pkg::SAMPLE_BITS-1:0] sample;
   logic [aca_pkg::CHAN_BITS-1:0]   channel;

   modport source (output valid, output sample, output channel, input ready);
   modport sink   (input valid, input sample, input channel, output ready);
endinterface

interface aca_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [aca_pkg::CHAN_BITS-1:0]   out_channel;
   logic [aca_pkg::SAMPLE_BITS-1:0] average;

   modport source (output valid, output out_channel, output average, input ready);
   modport sink   (input valid, input out_channel, input average, output ready);
endinterface

// ===== rtl/aca_update.sv =====
// Per-sample accumulate, emit decision and average calculation for one channel entry.
module aca_update (
   input  aca_pkg::chan_entry_type          entry_cur,
   input  logic [aca_pkg::SAMPLE_BITS-1:0]  sample,
   input  aca_pkg::cfg_type                 cfg,
   output aca_pkg::chan_entry_type          entry_next,
   output logic                             emit,
   output logic [aca_pkg::SAMPLE_BITS-1:0]  average
);

   logic [aca_pkg::SUM_BITS-1:0]    sum_new;
   logic [aca_pkg::SAMPLE_BITS-1:0] min_new;
   logic [aca_pkg::SAMPLE_BITS-1:0] max_new;
   logic [aca_pkg::COUNT_BITS-1:0]  count_new;
   logic [aca_pkg::DEPTH_BITS-1:0]  shift;
   logic [aca_pkg::COUNT_BITS-1:0]  target;
   logic [aca_pkg::WIDE_BITS-1:0]   mean_wide;
   logic [aca_pkg::WIDE_BITS-1:0]   trim_wide;
   logic [aca_pkg::WIDE_BITS-1:0]   avg_wide;

   // The count never passes the largest target, so the sum fits without wrapping.
   assign sum_new   = entry_cur.sum + aca_pkg::SUM_BITS'(sample);
   assign min_new   = (sample < entry_cur.min_val) ? sample : entry_cur.min_val;
   assign max_new   = (sample > entry_cur.max_val) ? sample : entry_cur.max_val;
   assign count_new = entry_cur.count + aca_pkg::COUNT_BITS'(1);

   assign shift = (cfg.depth_log2 > aca_pkg::DEPTH_BITS'(aca_pkg::MAX_DEPTH_LOG2)) ?
                  aca_pkg::DEPTH_BITS'(aca_pkg::MAX_DEPTH_LOG2) : cfg.depth_log2;

   always_comb begin
      if (cfg.mode == aca_pkg::MODE_TRIMMED) begin
         target = aca_pkg::COUNT_BITS'(aca_pkg::TRIM_DEPTH);
      end else begin
         target = aca_pkg::COUNT_BITS'(1) << shift;
      end
   end

   assign emit = (count_new >= target);

   assign mean_wide = (aca_pkg::WIDE_BITS'(sum_new) + aca_pkg::WIDE_BITS'(target >> 1)) >> shift;

   // With at least two samples the min and max are distinct terms of the sum.
   assign trim_wide = (aca_pkg::WIDE_BITS'(sum_new) - aca_pkg::WIDE_BITS'(min_new)
                       - aca_pkg::WIDE_BITS'(max_new) + aca_pkg::WIDE_BITS'(1)) >> 1;

   assign avg_wide = (cfg.mode == aca_pkg::MODE_TRIMMED) ? trim_wide : mean_wide;

   assign average = (avg_wide > aca_pkg::WIDE_BITS'(aca_pkg::SAMPLE_MAX)) ?
                    aca_pkg::SAMPLE_MAX : avg_wide[aca_pkg::SAMPLE_BITS-1:0];

   always_comb begin
      if (emit) begin
         entry_next = aca_pkg::CLEAR_ENTRY;
      end else begin
         entry_next.sum     = sum_new;
         entry_next.min_val = min_new;
         entry_next.max_val = max_new;
         entry_next.count   = count_new;
      end
   end

endmodule

// ===== rtl/aca_chan_state.sv =====
// Per-channel accumulator registers with a single read and write port.
module aca_chan_state (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           write_en,
   input  logic [aca_pkg::CHAN_BITS-1:0]  write_channel,
   input  aca_pkg::chan_entry_type        write_entry,
   input  logic [aca_pkg::CHAN_BITS-1:0]  read_channel,
   output aca_pkg::chan_entry_type        read_entry
);

   aca_pkg::chan_entry_type entry_ff [aca_pkg::CHANNELS];
   aca_pkg::chan_entry_type entry_in [aca_pkg::CHANNELS];

   always_comb begin
      for (int c = 0; c < aca_pkg::CHANNELS; c++) begin
         if (write_en && (int'(write_channel) == c)) begin
            entry_in[c] = write_entry;
         end else begin
            entry_in[c] = entry_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < aca_pkg::CHANNELS; c++) begin
         if (reset) begin
            entry_ff[c] <= aca_pkg::CLEAR_ENTRY;
         end else begin
            entry_ff[c] <= entry_in[c];
         end
      end
   end

   assign read_entry = entry_ff[read_channel];

endmodule

// ===== rtl/adc_channel_averager.sv =====
// Per-channel averager: accepts one sample beat per clock and returns one result beat each
// time a channel reaches its sample target. An accepted sample is held in an input
// register, then, as it leaves that register, the channel's sum, minimum, maximum and count
// are updated and, on reaching the target, the rounded mean (or trimmed mean of four) is
// loaded into the result register and the channel is cleared. Sustained rate is one sample
// per cycle while the result side does not stall. Input ready drops only while a result is
// held and the sink is not ready.
// Write the mode and depth registers only while no samples are in flight.
module adc_channel_averager (
   input  logic                                clock,
   input  logic                                reset,
   aca_req_if.sink                             req_stream,
   aca_rsp_if.source                           rsp_stream,
   input  logic                                csr_write_enable,
   input  logic [aca_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [aca_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   aca_pkg::cfg_type                 cfg_ff, cfg_in;

   logic                             s1_valid_ff, s1_valid_in;
   logic [aca_pkg::SAMPLE_BITS-1:0]  s1_sample_ff, s1_sample_in;
   logic [aca_pkg::CHAN_BITS-1:0]    s1_channel_ff, s1_channel_in;

   logic                             out_valid_ff, out_valid_in;
   logic [aca_pkg::CHAN_BITS-1:0]    out_channel_ff, out_channel_in;
   logic [aca_pkg::SAMPLE_BITS-1:0]  out_average_ff, out_average_in;

   logic                             req_beat;
   logic                             s1_advance;
   logic                             channel_ok;
   logic                             state_write;
   logic                             emit;
   logic [aca_pkg::SAMPLE_BITS-1:0]  average;
   aca_pkg::chan_entry_type          entry_cur;
   aca_pkg::chan_entry_type          entry_next;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (aca_pkg::csr_index_type'(csr_index))
            aca_pkg::REG_MODE: begin
               cfg_in.mode = aca_pkg::mode_type'(csr_write_data[0]);
            end
            aca_pkg::REG_DEPTH_LOG2: begin
               cfg_in.depth_log2 = csr_write_data[aca_pkg::DEPTH_BITS-1:0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode       <= aca_pkg::MODE_MEAN;
         cfg_ff.depth_log2 <= aca_pkg::DEPTH_LOG2_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register stage.
   assign s1_advance       = s1_valid_ff && (!out_valid_ff || rsp_stream.ready);
   assign req_stream.ready = !s1_valid_ff || s1_advance;
   assign req_beat         = req_stream.valid && req_stream.ready;

   always_comb begin
      s1_valid_in   = req_beat || (s1_valid_ff && !s1_advance);
      s1_sample_in  = req_beat ? req_stream.sample  : s1_sample_ff;
      s1_channel_in = req_beat ? req_stream.channel : s1_channel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_sample_ff  <= s1_sample_in;
      s1_channel_ff <= s1_channel_in;
   end

   // Accumulate stage.
   assign channel_ok  = (int'(s1_channel_ff) < aca_pkg::CHANNELS);
   assign state_write = s1_advance && channel_ok;

   aca_chan_state u_chan_state (
      .clock         (clock),
      .reset         (reset),
      .write_en      (state_write),
      .write_channel (s1_channel_ff),
      .write_entry   (entry_next),
      .read_channel  (s1_channel_ff),
      .read_entry    (entry_cur)
   );

   aca_update u_update (
      .entry_cur  (entry_cur),
      .sample     (s1_sample_ff),
      .cfg        (cfg_ff),
      .entry_next (entry_next),
      .emit       (emit),
      .average    (average)
   );

   // Result register.
   always_comb begin
      out_channel_in = out_channel_ff;
      out_average_in = out_average_ff;
      if (state_write && emit) begin
         out_valid_in   = 1'b1;
         out_channel_in = s1_channel_ff;
         out_average_in = average;
      end else if (rsp_stream.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_channel_ff <= out_channel_in;
      out_average_ff <= out_average_in;
   end

   assign rsp_stream.valid       = out_valid_ff;
   assign rsp_stream.out_channel = out_channel_ff;
   assign rsp_stream.average     = out_average_ff;

endmodule

// ===== rtl/aca_checker.sv =====
// Port-level checks for the ADC channel averager, bound to the top level.
module aca_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [aca_pkg::CHAN_BITS-1:0]   rsp_out_channel,
   input logic [aca_pkg::SAMPLE_BITS-1:0] rsp_average
);

   // A held result beat keeps its payload until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_channel) && $stable(rsp_average))
      else $error("result beat changed while stalled");

   // The sample side stalls only behind a stalled result.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("sample side stalled without a stalled result");

   // A new result follows an accepted sample beat.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result beat without a matching sample beat");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind adc_channel_averager aca_checker u_aca_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_stream.valid),
   .req_ready       (req_stream.ready),
   .rsp_valid       (rsp_stream.valid),
   .rsp_ready       (rsp_stream.ready),
   .rsp_out_channel (rsp_stream.out_channel),
   .rsp_average     (rsp_stream.average)
);

// ===== sim/aca_average_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard that predicts per-channel averages from observed sample beats and checks result beats.
module aca_average_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [aca_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [aca_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [aca_pkg::SAMPLE_BITS-1:0]    req_sample,
   input  logic [aca_pkg::CHAN_BITS-1:0]      req_channel,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [aca_pkg::CHAN_BITS-1:0]      rsp_out_channel,
   input  logic [aca_pkg::SAMPLE_BITS-1:0]    rsp_average,
   output int                                 fail_count,
   output int                                 averages_pending,
   output int                                 averages_checked
);

   typedef struct packed {
      logic [aca_pkg::CHAN_BITS-1:0]   chan;
      logic [aca_pkg::SAMPLE_BITS-1:0] average;
   } chan_average_type;

   aca_pkg::chan_entry_type bank [aca_pkg::CHANNELS];
   aca_pkg::cfg_type        cfg;
   chan_average_type        averages_due [$];
   int                      mismatches = 0;
   int                      checked = 0;

   // Adds one sample to its channel; returns 1 when the channel completes an average.
   function automatic bit fold_sample(input logic [aca_pkg::CHAN_BITS-1:0] chan,
                                      input logic [aca_pkg::SAMPLE_BITS-1:0] sample,
                                      output logic [aca_pkg::SAMPLE_BITS-1:0] average);
      aca_pkg::chan_entry_type entry;
      int unsigned             shift;
      int unsigned             target;
      int unsigned             wide;
      entry = bank[chan];
      entry.sum = entry.sum + sample;
      if (sample < entry.min_val) entry.min_val = sample;
      if (sample > entry.max_val) entry.max_val = sample;
      entry.count = entry.count + 1'b1;
      shift = (cfg.depth_log2 > aca_pkg::MAX_DEPTH_LOG2) ?
              aca_pkg::MAX_DEPTH_LOG2 : cfg.depth_log2;
      target = (cfg.mode == aca_pkg::MODE_TRIMMED) ? aca_pkg::TRIM_DEPTH : (1 << shift);
      average = '0;
      // A channel left over from an earlier setting may already be past the target.
      if (entry.count < target) begin
         bank[chan] = entry;
         return 1'b0;
      end
      if (cfg.mode == aca_pkg::MODE_TRIMMED) begin
         wide = entry.sum;
         wide = (wide - entry.min_val - entry.max_val + 1) >> 1;
      end else begin
         wide = (entry.sum + (target >> 1)) >> shift;
      end
      if (wide > aca_pkg::SAMPLE_MAX) wide = aca_pkg::SAMPLE_MAX;
      average = wide[aca_pkg::SAMPLE_BITS-1:0];
      bank[chan] = aca_pkg::CLEAR_ENTRY;
      return 1'b1;
   endfunction

   always @(posedge clock) begin : watch
      chan_average_type                due;
      logic [aca_pkg::SAMPLE_BITS-1:0] average;
      if (reset) begin
         foreach (bank[c]) bank[c] = aca_pkg::CLEAR_ENTRY;
         cfg = '{mode: aca_pkg::MODE_MEAN, depth_log2: aca_pkg::DEPTH_LOG2_RESET};
         averages_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (aca_pkg::csr_index_type'(csr_index))
               aca_pkg::REG_MODE:       cfg.mode = aca_pkg::mode_type'(csr_write_data[0]);
               aca_pkg::REG_DEPTH_LOG2: cfg.depth_log2 = csr_write_data;
               default:                 ;
            endcase
         end
         // Results are matched before new samples are folded in, so a beat never
         // pairs with an expectation raised at the same edge.
         if (rsp_valid && rsp_ready) begin
            if (averages_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result beat: channel %0d average %0d",
                           $realtime, rsp_out_channel, rsp_average);
            end else begin
               due = averages_due.pop_front();
               checked++;
               if (rsp_out_channel !== due.chan || rsp_average !== due.average) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: mismatch: expected channel %0d average %0d, ",
                               "got channel %0d average %0d"},
                              $realtime, due.chan, due.average, rsp_out_channel,
                              rsp_average);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (fold_sample(req_channel, req_sample, average))
               averages_due.push_back('{chan: req_channel, average: average});
         end
      end
      fail_count       <= mismatches;
      averages_pending <= averages_due.size();
      averages_checked <= checked;
   end

endmodule

// ===== sim/tb_adc_channel_averager.sv =====
`timescale 1ns / 1ps
// Top-level testbench for the ADC channel averager: stimulus, watchdog and verdict.
module tb_adc_channel_averager;

   localparam int PLAN_PHASES     = 12;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int STALL_LIMIT     = 1000;
   localparam int SETTLE_CYCLES   = 4;

   logic                               clock;
   logic                               reset;
   logic                               csr_write_enable;
   logic [aca_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [aca_pkg::CSR_DATA_BITS-1:0]  csr_write_data;
   int                                 fail_count;
   int                                 averages_pending;
   int                                 averages_checked;
   int                                 samples_sent = 0;
   int                                 settings_used = 0;
   int                                 quiet_cycles = 0;
   bit                                 idle_on = 1'b1;
   bit                                 hold_off_pending = 1'b0;

   aca_req_if req_if ();
   aca_rsp_if rsp_if ();

   adc_channel_averager dut (
      .clock            (clock),
      .reset            (reset),
      .req_stream       (req_if),
      .rsp_stream       (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   aca_average_checker average_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_if.valid),
      .req_ready        (req_if.ready),
      .req_sample       (req_if.sample),
      .req_channel      (req_if.channel),
      .rsp_valid        (rsp_if.valid),
      .rsp_ready        (rsp_if.ready),
      .rsp_out_channel  (rsp_if.out_channel),
      .rsp_average      (rsp_if.average),
      .fail_count       (fail_count),
      .averages_pending (averages_pending),
      .averages_checked (averages_checked)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Offers one sample beat and returns at the falling edge after it is taken.
   task automatic send_sample(input logic [aca_pkg::SAMPLE_BITS-1:0] sample,
                              input logic [aca_pkg::CHAN_BITS-1:0] chan);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.sample  <= sample;
      req_if.channel <= chan;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
      samples_sent++;
   endtask

   // Waits until the block is idle, then writes both registers.
   task automatic apply_setting(input aca_pkg::mode_type mode,
                                input logic [aca_pkg::DEPTH_BITS-1:0] depth_log2);
      req_if.valid <= 1'b0;
      while (averages_pending != 0) @(negedge clock);
      // A last sample that completes nothing may still be in the pipeline.
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= aca_pkg::REG_MODE;
      csr_write_data   <= aca_pkg::CSR_DATA_BITS'(mode);
      @(negedge clock);
      csr_index        <= aca_pkg::REG_DEPTH_LOG2;
      csr_write_data   <= depth_log2;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   initial begin : sink_side
      rsp_if.ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("No beat moved for %0d cycles; giving up.", quiet_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      aca_pkg::cfg_type                plan [PLAN_PHASES];
      int                              plan_items [PLAN_PHASES];
      logic [aca_pkg::CHAN_BITS-1:0]   focus;
      logic [aca_pkg::CHAN_BITS-1:0]   chan;
      logic [aca_pkg::SAMPLE_BITS-1:0] sample;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = aca_pkg::REG_MODE;
      csr_write_data   = '0;
      req_if.valid     = 1'b0;
      req_if.sample    = '0;
      req_if.channel   = '0;
      plan = '{'{aca_pkg::MODE_MEAN, 3'd0}, '{aca_pkg::MODE_MEAN, 3'd7},
               '{aca_pkg::MODE_TRIMMED, 3'd7}, '{aca_pkg::MODE_MEAN, 3'd1},
               '{aca_pkg::MODE_TRIMMED, 3'd0}, '{aca_pkg::MODE_MEAN, 3'd3},
               '{aca_pkg::MODE_MEAN, 3'd5}, '{aca_pkg::MODE_MEAN, 3'd0},
               '{aca_pkg::MODE_MEAN, 3'd2}, '{aca_pkg::MODE_MEAN, 3'd2},
               '{aca_pkg::MODE_MEAN, 3'd2}, '{aca_pkg::MODE_MEAN, 3'd2}};
      plan_items = '{50, 180, 50, 50, 50, 50, 60, 40, 40, 40, 40, 40};
      for (int p = 8; p < 11; p++)
         plan[p] = '{aca_pkg::mode_type'($urandom_range(0, 1)),
                     aca_pkg::DEPTH_BITS'($urandom_range(0, 7))};
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings, mean of four: full scale, rounding up at one half,
      // rounding down below it, and alternating bit patterns.
      for (int i = 0; i < 4; i++) begin
         send_sample(aca_pkg::SAMPLE_MAX, 2'd0);
         send_sample((i == 3) ? 12'd2 : 12'd0, 2'd1);
         send_sample((i == 0) ? 12'd1 : 12'd0, 2'd2);
         send_sample(i[0] ? 12'h555 : 12'hAAA, 2'd3);
      end
      // Trimmed mean drops the extremes of four samples.
      apply_setting(aca_pkg::MODE_TRIMMED, 3'd2);
      send_sample(aca_pkg::SAMPLE_MAX, 2'd0);
      send_sample(12'd0, 2'd0);
      send_sample(12'd100, 2'd0);
      send_sample(12'd201, 2'd0);
      // A depth of one sample passes each value straight through.
      apply_setting(aca_pkg::MODE_MEAN, 3'd0);
      send_sample(aca_pkg::SAMPLE_MAX, 2'd1);
      send_sample(12'h555, 2'd2);
      send_sample(12'hAAA, 2'd3);

      // Phases keep partly filled channels across setting changes, which exercises
      // early emission and saturation when the target shrinks.
      for (int p = 0; p < PLAN_PHASES; p++) begin
         idle_on = !(p == 0 || p == 3 || p == PLAN_PHASES - 1);
         apply_setting(plan[p].mode, plan[p].depth_log2);
         if (p == 0) hold_off_pending = 1'b1;
         focus = $urandom_range(0, 3);
         for (int n = 0; n < plan_items[p]; n++) begin
            if (plan[p].mode == aca_pkg::MODE_MEAN && plan[p].depth_log2 >= 5 &&
                $urandom_range(0, 9) < 8)
               chan = focus;
            else
               chan = $urandom_range(0, 3);
            case ($urandom_range(0, 9))
               0:       sample = '0;
               1:       sample = aca_pkg::SAMPLE_MAX;
               2:       sample = $urandom_range(0, 15);
               3:       sample = $urandom_range(4080, 4095);
               default: sample = $urandom_range(0, 4095);
            endcase
            send_sample(sample, chan);
         end
      end
      req_if.valid <= 1'b0;
      while (averages_pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("Sent %0d samples under %0d register settings in both modes,",
               samples_sent, settings_used);
      $display("with a long result stall; checked %0d averages, %0d failures.",
               averages_checked, fail_count);
      if (fail_count == 0 && averages_pending == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/aca_pkg.sv
rtl/aca_stream_ifs.sv
rtl/aca_update.sv
rtl/aca_chan_state.sv
rtl/adc_channel_averager.sv
rtl/aca_checker.sv
sim/aca_average_checker.sv
sim/tb_adc_channel_averager.sv
